// ===== rtl/core/mer_pkg.sv =====
// shared types, widths and codes for the midpoint ellipse rasterizer
`default_nettype none
package mer_pkg;

   localparam int COORD_BITS  = 11;
   localparam int RADIUS_BITS = 10;
   localparam int OUT_W       = 13;

   // offset x can reach rx, offset y starts at ry
   localparam int OFS_W  = RADIUS_BITS + 1;
   localparam int SQ_W   = 2 * RADIUS_BITS;
   localparam int ODD_W  = OFS_W + 1;
   localparam int T_W    = 2 * ODD_W;
   localparam int U_W    = 2 * OFS_W;
   localparam int MA_W   = T_W;
   localparam int MB_W   = SQ_W;
   localparam int PROD_W = MA_W + MB_W;
   localparam int DEC_W  = PROD_W + 4;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_RX,
      ST_SQ_RY,
      ST_SQ_WR,
      ST_MUL_X,
      ST_MUL_Y,
      ST_UPD,
      ST_TR_A,
      ST_TR_B,
      ST_TR_C,
      ST_TR_D,
      ST_TR_E,
      ST_TR_F,
      ST_EMIT
   } mer_state_type;

   typedef enum logic [3:0] {
      M_RXRX,
      M_RYRY,
      M_RY2X,
      M_RX2Y,
      M_ODD,
      M_YM1,
      M_RY2T,
      M_RX2U,
      M_RX2RY2
   } mer_mul_type;

   typedef enum logic [2:0] {
      D_HOLD,
      D_INIT,
      D_STEP,
      D_TR_SET,
      D_TR_ADD,
      D_TR_SUB
   } mer_dop_type;

   typedef struct packed {
      logic        load;
      logic        step_xy;
      mer_mul_type mul_sel;
      logic        wr_rx2;
      logic        wr_ry2;
      logic        wr_px;
      logic        wr_t;
      logic        wr_u;
      logic        set_reg2;
      mer_dop_type d_op;
      logic        emit;
      logic        emit_idle;
   } mer_cmd_type;

   typedef struct packed {
      logic running;
      logic trans_due;
   } mer_status_type;

endpackage
`default_nettype wire

// ===== rtl/core/mer_ctrl.sv =====
// sequencer for the ellipse rasterizer: start, step and region change sequences
`default_nettype none
module mer_ctrl
   import mer_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_command,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire mer_status_type status,
   output mer_cmd_type         cmd
);

   mer_state_type state_ff, state_in;
   logic start_ff, start_in;
   logic idle_ff, idle_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_START) begin
                  state_in = ST_SQ_RX;
               end else if (status.running) begin
                  state_in = ST_MUL_X;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SQ_RX: state_in = ST_SQ_RY;
         ST_SQ_RY: state_in = ST_SQ_WR;
         ST_SQ_WR: state_in = ST_MUL_X;
         ST_MUL_X: state_in = ST_MUL_Y;
         ST_MUL_Y: state_in = ST_UPD;
         ST_UPD:   state_in = status.trans_due ? ST_TR_A : ST_EMIT;
         ST_TR_A:  state_in = ST_TR_B;
         ST_TR_B:  state_in = ST_TR_C;
         ST_TR_C:  state_in = ST_TR_D;
         ST_TR_D:  state_in = ST_TR_E;
         ST_TR_E:  state_in = ST_TR_F;
         ST_TR_F:  state_in = ST_EMIT;
         ST_EMIT:  state_in = out_free ? ST_IDLE : ST_EMIT;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.mul_sel   = M_RXRX;
      cmd.d_op      = D_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load    = accept && (req_command == CMD_START);
            cmd.step_xy = accept && (req_command == CMD_STEP) && status.running;
         end
         ST_SQ_RX: cmd.mul_sel = M_RXRX;
         ST_SQ_RY: begin
            cmd.wr_rx2  = 1'b1;
            cmd.mul_sel = M_RYRY;
         end
         ST_SQ_WR: cmd.wr_ry2 = 1'b1;
         ST_MUL_X: cmd.mul_sel = M_RY2X;
         ST_MUL_Y: begin
            cmd.wr_px   = 1'b1;
            cmd.mul_sel = M_RX2Y;
         end
         ST_UPD: begin
            if (status.trans_due) begin
               cmd.set_reg2 = 1'b1;
            end else begin
               cmd.d_op = start_ff ? D_INIT : D_STEP;
            end
         end
         ST_TR_A: cmd.mul_sel = M_ODD;
         ST_TR_B: begin
            cmd.wr_t    = 1'b1;
            cmd.mul_sel = M_YM1;
         end
         ST_TR_C: begin
            cmd.wr_u    = 1'b1;
            cmd.mul_sel = M_RY2T;
         end
         ST_TR_D: begin
            cmd.d_op    = D_TR_SET;
            cmd.mul_sel = M_RX2U;
         end
         ST_TR_E: begin
            cmd.d_op    = D_TR_ADD;
            cmd.mul_sel = M_RX2RY2;
         end
         ST_TR_F: cmd.d_op = D_TR_SUB;
         ST_EMIT: begin
            cmd.emit      = out_free && !idle_ff;
            cmd.emit_idle = out_free && idle_ff;
         end
         default: begin
            cmd.d_op = D_HOLD;
         end
      endcase
   end

   always_comb begin
      start_in = start_ff;
      idle_in  = idle_ff;
      if (accept) begin
         start_in = (req_command == CMD_START);
         idle_in  = (req_command == CMD_STEP) && !status.running;
      end
      if (cmd.emit || cmd.emit_idle) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         idle_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/mer_dp.sv =====
// datapath of the ellipse rasterizer: offsets, decision value, shared multiplier, result register
`default_nettype none
module mer_dp
   import mer_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mer_cmd_type             cmd,
   output mer_status_type               status,
   input  wire logic [COORD_BITS-1:0]   req_centre_x,
   input  wire logic [COORD_BITS-1:0]   req_centre_y,
   input  wire logic [RADIUS_BITS-1:0]  req_radius_horiz,
   input  wire logic [RADIUS_BITS-1:0]  req_radius_vert,
   output logic signed [OUT_W-1:0]      rsp_x_right,
   output logic signed [OUT_W-1:0]      rsp_x_left,
   output logic signed [OUT_W-1:0]      rsp_y_below,
   output logic signed [OUT_W-1:0]      rsp_y_above,
   output logic                         rsp_point_valid,
   output logic                         rsp_done_res
);

   logic [COORD_BITS-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [RADIUS_BITS-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [SQ_W-1:0]        rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic [OFS_W-1:0]       x_ff, x_in, y_ff, y_in;
   logic signed [DEC_W-1:0] d_ff, d_in;
   logic                   reg2_ff, reg2_in;
   logic                   running_ff, running_in;
   logic                   diag_ff, diag_in;
   logic [PROD_W-1:0]      px_ff, px_in;
   logic [T_W-1:0]         t_ff, t_in;
   logic [U_W-1:0]         u_ff, u_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [OUT_W-1:0]       xr_ff, xr_in, xl_ff, xl_in, yb_ff, yb_in, ya_ff, ya_in;
   logic                   pv_ff, pv_in, dn_ff, dn_in;

   logic [MA_W-1:0]        mul_a;
   logic [MB_W-1:0]        mul_b;
   logic [ODD_W-1:0]       odd;
   logic [OFS_W-1:0]       ym1;
   logic                   d_neg, d_pos, y_zero;
   logic signed [DEC_W-1:0] prod_d, px_d, rx2_d, ry2_d;

   assign d_neg  = d_ff[DEC_W-1];
   assign d_pos  = !d_neg && (d_ff != '0);
   assign y_zero = (y_ff == '0);
   // 2x+1 and |y-1|
   assign odd    = {x_ff, 1'b1};
   assign ym1    = y_zero ? OFS_W'(1) : (y_ff - OFS_W'(1));

   assign prod_d = $signed(DEC_W'(prod_ff));
   assign px_d   = $signed(DEC_W'(px_ff));
   assign rx2_d  = $signed(DEC_W'(rx2_ff));
   assign ry2_d  = $signed(DEC_W'(ry2_ff));

   assign status.running   = running_ff;
   assign status.trans_due = !reg2_ff && (px_ff >= prod_ff);

   always_comb begin
      case (cmd.mul_sel)
         M_RXRX: begin
            mul_a = MA_W'(rx_ff);
            mul_b = MB_W'(rx_ff);
         end
         M_RYRY: begin
            mul_a = MA_W'(ry_ff);
            mul_b = MB_W'(ry_ff);
         end
         M_RY2X: begin
            mul_a = MA_W'(x_ff);
            mul_b = ry2_ff;
         end
         M_RX2Y: begin
            mul_a = MA_W'(y_ff);
            mul_b = rx2_ff;
         end
         M_ODD: begin
            mul_a = MA_W'(odd);
            mul_b = MB_W'(odd);
         end
         M_YM1: begin
            mul_a = MA_W'(ym1);
            mul_b = MB_W'(ym1);
         end
         M_RY2T: begin
            mul_a = t_ff;
            mul_b = ry2_ff;
         end
         M_RX2U: begin
            mul_a = MA_W'(u_ff);
            mul_b = rx2_ff;
         end
         M_RX2RY2: begin
            mul_a = MA_W'(ry2_ff);
            mul_b = rx2_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      rx_in      = rx_ff;
      ry_in      = ry_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      reg2_in    = reg2_ff;
      running_in = running_ff;
      diag_in    = diag_ff;
      rx2_in     = cmd.wr_rx2 ? prod_ff[SQ_W-1:0] : rx2_ff;
      ry2_in     = cmd.wr_ry2 ? prod_ff[SQ_W-1:0] : ry2_ff;
      px_in      = cmd.wr_px ? prod_ff : px_ff;
      t_in       = cmd.wr_t ? prod_ff[T_W-1:0] : t_ff;
      u_in       = cmd.wr_u ? prod_ff[U_W-1:0] : u_ff;

      if (cmd.load) begin
         cx_in      = req_centre_x;
         cy_in      = req_centre_y;
         rx_in      = req_radius_horiz;
         ry_in      = req_radius_vert;
         x_in       = '0;
         y_in       = OFS_W'(req_radius_vert);
         reg2_in    = 1'b0;
         running_in = 1'b1;
      end

      if (cmd.step_xy) begin
         if (!reg2_ff) begin
            diag_in = !d_neg;
            x_in    = x_ff + OFS_W'(1);
            if (!d_neg) begin
               y_in = y_ff - OFS_W'(1);
            end
         end else begin
            diag_in = !d_pos;
            y_in    = y_ff - OFS_W'(1);
            if (!d_pos) begin
               x_in = x_ff + OFS_W'(1);
            end
         end
      end

      if (cmd.set_reg2) begin
         reg2_in = 1'b1;
      end

      if (cmd.emit && y_zero) begin
         running_in = 1'b0;
      end
   end

   always_comb begin
      case (cmd.d_op)
         D_INIT:   d_in = (ry2_d <<< 2) - (prod_d <<< 2) + rx2_d;
         D_STEP: begin
            if (!reg2_ff) begin
               d_in = d_ff + (ry2_d <<< 2) + (px_d <<< 3)
                    - (diag_ff ? (prod_d <<< 3) : '0);
            end else begin
               d_in = d_ff + (rx2_d <<< 2) - (prod_d <<< 3)
                    + (diag_ff ? (px_d <<< 3) : '0);
            end
         end
         D_TR_SET: d_in = prod_d;
         D_TR_ADD: d_in = d_ff + (prod_d <<< 2);
         D_TR_SUB: d_in = d_ff - (prod_d <<< 2);
         default:  d_in = d_ff;
      endcase
   end

   always_comb begin
      xr_in = xr_ff;
      xl_in = xl_ff;
      yb_in = yb_ff;
      ya_in = ya_ff;
      pv_in = pv_ff;
      dn_in = dn_ff;
      if (cmd.emit) begin
         xr_in = OUT_W'(cx_ff) + OUT_W'(x_ff);
         xl_in = OUT_W'(cx_ff) - OUT_W'(x_ff);
         yb_in = OUT_W'(cy_ff) + OUT_W'(y_ff);
         ya_in = OUT_W'(cy_ff) - OUT_W'(y_ff);
         pv_in = 1'b1;
         dn_in = y_zero;
      end else if (cmd.emit_idle) begin
         xr_in = '0;
         xl_in = '0;
         yb_in = '0;
         ya_in = '0;
         pv_in = 1'b0;
         dn_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg2_ff    <= 1'b0;
         running_ff <= 1'b0;
      end else begin
         reg2_ff    <= reg2_in;
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      rx2_ff  <= rx2_in;
      ry2_ff  <= ry2_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      d_ff    <= d_in;
      diag_ff <= diag_in;
      px_ff   <= px_in;
      t_ff    <= t_in;
      u_ff    <= u_in;
      prod_ff <= prod_in;
      xr_ff   <= xr_in;
      xl_ff   <= xl_in;
      yb_ff   <= yb_in;
      ya_ff   <= ya_in;
      pv_ff   <= pv_in;
      dn_ff   <= dn_in;
   end

   assign rsp_x_right     = $signed(xr_ff);
   assign rsp_x_left      = $signed(xl_ff);
   assign rsp_y_below     = $signed(yb_ff);
   assign rsp_y_above     = $signed(ya_ff);
   assign rsp_point_valid = pv_ff;
   assign rsp_done_res    = dn_ff;

endmodule
`default_nettype wire

// ===== rtl/core/midpoint_ellipse_rasterizer_top.sv =====
// top level of the midpoint ellipse rasterizer: sequencer plus datapath
// step transaction: MUL_X, MUL_Y, UPD, EMIT; no new request is taken before idle again
// start: SQ_RX, SQ_RY, SQ_WR, then as a step; region 2 entry adds TR_A to TR_F passes
// step while not running: IDLE then EMIT, gives an empty point set with done set
// one multiplier, one product a cycle, sets the sequences; a waiting result holds the
// next transaction in its last cycle until the result is taken
// synchronous active-high reset: sequencer idle, no ellipse running, no result pending
`default_nettype none
module midpoint_ellipse_rasterizer_top
   import mer_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_command,
   input  wire logic [COORD_BITS-1:0]   req_centre_x,
   input  wire logic [COORD_BITS-1:0]   req_centre_y,
   input  wire logic [RADIUS_BITS-1:0]  req_radius_horiz,
   input  wire logic [RADIUS_BITS-1:0]  req_radius_vert,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [OUT_W-1:0]      rsp_x_right,
   output logic signed [OUT_W-1:0]      rsp_x_left,
   output logic signed [OUT_W-1:0]      rsp_y_below,
   output logic signed [OUT_W-1:0]      rsp_y_above,
   output logic                         rsp_point_valid,
   output logic                         rsp_done_res
);

   mer_cmd_type    cmd;
   mer_status_type status;

   mer_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   mer_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_centre_x     (req_centre_x),
      .req_centre_y     (req_centre_y),
      .req_radius_horiz (req_radius_horiz),
      .req_radius_vert  (req_radius_vert),
      .rsp_x_right      (rsp_x_right),
      .rsp_x_left       (rsp_x_left),
      .rsp_y_below      (rsp_y_below),
      .rsp_y_above      (rsp_y_above),
      .rsp_point_valid  (rsp_point_valid),
      .rsp_done_res     (rsp_done_res)
   );

   // an empty point set always marks the ellipse finished with zero coordinates
   a_empty_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_point_valid |-> rsp_done_res && rsp_x_right == '0 && rsp_y_above == '0)
      else $error("empty result without done or with coordinates");

   // a start transaction always leaves an ellipse running
   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_START |=> status.running)
      else $error("start transaction did not set running");

   // while taking transactions the sequencer issues no decision update and no result load
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> cmd.d_op == D_HOLD && !cmd.emit && !cmd.emit_idle)
      else $error("datapath command issued while idle");

endmodule
`default_nettype wire

// ===== tb/midpoint_ellipse_rasterizer_top_tb.sv =====
// self-checking testbench for the midpoint ellipse rasterizer top level
`timescale 1ns / 1ps
module midpoint_ellipse_rasterizer_top_tb
   import mer_pkg::*;
();

   localparam int DIR_N       = 25;
   localparam int RAND_ITEMS  = 450;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_LEN    = 150;
   localparam int DRAIN_WAIT  = 40;

   typedef struct packed {
      logic signed [OUT_W-1:0] x_right;
      logic signed [OUT_W-1:0] x_left;
      logic signed [OUT_W-1:0] y_below;
      logic signed [OUT_W-1:0] y_above;
      logic                    point_valid;
      logic                    done_res;
   } point_set_type;

   typedef struct packed {
      logic                   cmd;
      logic [COORD_BITS-1:0]  cx;
      logic [COORD_BITS-1:0]  cy;
      logic [RADIUS_BITS-1:0] rx;
      logic [RADIUS_BITS-1:0] ry;
      logic                   known;
      point_set_type          want;
   } stim_row_type;

   localparam point_set_type NO_SET   = '0;
   localparam point_set_type IDLE_SET = '{0, 0, 0, 0, 1'b0, 1'b1};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_command = CMD_STEP;
   logic [COORD_BITS-1:0]   req_centre_x = '0;
   logic [COORD_BITS-1:0]   req_centre_y = '0;
   logic [RADIUS_BITS-1:0]  req_radius_horiz = '0;
   logic [RADIUS_BITS-1:0]  req_radius_vert = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_x_right;
   logic signed [OUT_W-1:0] rsp_x_left;
   logic signed [OUT_W-1:0] rsp_y_below;
   logic signed [OUT_W-1:0] rsp_y_above;
   logic                    rsp_point_valid;
   logic                    rsp_done_res;

   midpoint_ellipse_rasterizer_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_centre_x     (req_centre_x),
      .req_centre_y     (req_centre_y),
      .req_radius_horiz (req_radius_horiz),
      .req_radius_vert  (req_radius_vert),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_x_right      (rsp_x_right),
      .rsp_x_left       (rsp_x_left),
      .rsp_y_below      (rsp_y_below),
      .rsp_y_above      (rsp_y_above),
      .rsp_point_valid  (rsp_point_valid),
      .rsp_done_res     (rsp_done_res)
   );

   always #5 clock = ~clock;

   // ellipse tracer state kept by the testbench
   logic [COORD_BITS-1:0]   org_x = '0;
   logic [COORD_BITS-1:0]   org_y = '0;
   logic [SQ_W-1:0]         rx_sq = '0;
   logic [SQ_W-1:0]         ry_sq = '0;
   logic signed [OFS_W:0]   cur_x = '0;
   logic signed [OFS_W:0]   cur_y = '0;
   logic signed [DEC_W-1:0] dec4 = '0;
   logic                    past_switch = 1'b0;
   logic                    tracing = 1'b0;

   point_set_type point_sets_due[$];
   int         err_count = 0;
   int         items_sent = 0;
   int         got_count = 0;
   int         hold_left = 0;
   bit         held_off = 1'b0;
   logic       calm = 1'b0;
   int         stall_cycles = 0;

   // directed rows: extremes, idle steps, restarts, flat and vertical ellipses
   stim_row_type dir_rows [DIR_N] = '{
      '{CMD_STEP,  0, 0, 0, 0, 1'b1, IDLE_SET},
      '{CMD_START, 0, 0, 0, 0, 1'b1, '{0, 0, 0, 0, 1'b1, 1'b1}},
      '{CMD_STEP,  2047, 2047, 1023, 1023, 1'b1, IDLE_SET},
      '{CMD_START, 2047, 2047, 1023, 0, 1'b1, '{2047, 2047, 2047, 2047, 1'b1, 1'b1}},
      '{CMD_START, 2047, 2047, 1023, 1023, 1'b1, '{2047, 2047, 3070, 1024, 1'b1, 1'b0}},
      '{CMD_STEP,  0, 0, 0, 0, 1'b0, NO_SET},
      '{CMD_STEP,  2047, 2047, 1023, 1023, 1'b0, NO_SET},
      '{CMD_START, 0, 0, 1023, 1023, 1'b1, '{0, 0, 1023, -1023, 1'b1, 1'b0}},
      '{CMD_STEP,  0, 0, 0, 0, 1'b0, NO_SET},
      '{CMD_START, 100, 200, 0, 5, 1'b1, '{100, 100, 205, 195, 1'b1, 1'b0}},
      '{CMD_STEP,  0, 0, 0, 0, 1'b0, NO_SET},
      '{CMD_STEP,  0, 0, 0, 0, 1'b0, NO_SET},
      '{CMD_STEP,  0, 0, 0, 0, 1'b0, NO_SET},
      '{CMD_STEP,  0, 0, 0, 0, 1'b0, NO_SET},
      '{CMD_STEP,  0, 0, 0, 0, 1'b0, NO_SET},
      '{CMD_STEP,  1365, 682, 682, 341, 1'b1, IDLE_SET},
      '{CMD_START, 1365, 682, 682, 341, 1'b1, '{1365, 1365, 1023, 341, 1'b1, 1'b0}},
      '{CMD_STEP,  682, 1365, 341, 682, 1'b0, NO_SET},
      '{CMD_START, 1000, 1000, 3, 2, 1'b1, '{1000, 1000, 1002, 998, 1'b1, 1'b0}},
      '{CMD_STEP,  0, 0, 0, 0, 1'b0, NO_SET},
      '{CMD_STEP,  0, 0, 0, 0, 1'b0, NO_SET},
      '{CMD_STEP,  0, 0, 0, 0, 1'b0, NO_SET},
      '{CMD_STEP,  0, 0, 0, 0, 1'b0, NO_SET},
      '{CMD_STEP,  0, 0, 0, 0, 1'b0, NO_SET},
      '{CMD_STEP,  0, 0, 0, 0, 1'b0, NO_SET}
   };

   // switch to region 2 once the slope passes -1
   function automatic void try_region_two();
      longint a, b, x, y, t, u;
      a = longint'(rx_sq);
      b = longint'(ry_sq);
      x = longint'(cur_x);
      y = longint'(cur_y);
      if (!past_switch && b * x >= a * y) begin
         past_switch = 1'b1;
         t = 2 * x + 1;
         u = y - 1;
         dec4 = DEC_W'(b * t * t + 4 * a * u * u - 4 * a * b);
      end
   endfunction

   task automatic predict_point_set(input logic cmd, input logic [COORD_BITS-1:0] cx,
                                    input logic [COORD_BITS-1:0] cy,
                                    input logic [RADIUS_BITS-1:0] rx,
                                    input logic [RADIUS_BITS-1:0] ry,
                                    output point_set_type ps);
      longint a, b, x, y, d, ox, oy, rxl, ryl;
      ps = IDLE_SET;
      if (cmd == CMD_START) begin
         rxl = longint'(rx);
         ryl = longint'(ry);
         org_x = cx;
         org_y = cy;
         rx_sq = SQ_W'(rxl * rxl);
         ry_sq = SQ_W'(ryl * ryl);
         cur_x = '0;
         cur_y = (OFS_W+1)'(ry);
         dec4 = DEC_W'(4 * ryl * ryl - 4 * rxl * rxl * ryl + rxl * rxl);
         past_switch = 1'b0;
         tracing = 1'b1;
         try_region_two();
      end else if (!tracing) begin
         return;
      end else begin
         a = longint'(rx_sq);
         b = longint'(ry_sq);
         x = longint'(cur_x);
         y = longint'(cur_y);
         d = longint'(dec4);
         if (!past_switch) begin
            x++;
            if (d < 0) begin
               d += 4 * (2 * b * x + b);
            end else begin
               y--;
               d += 4 * (2 * b * x - 2 * a * y + b);
            end
         end else begin
            y--;
            if (d > 0) begin
               d += 4 * (a - 2 * a * y);
            end else begin
               x++;
               d += 4 * (2 * b * x - 2 * a * y + a);
            end
         end
         cur_x = (OFS_W+1)'(x);
         cur_y = (OFS_W+1)'(y);
         dec4 = DEC_W'(d);
         try_region_two();
      end
      ox = longint'(org_x);
      oy = longint'(org_y);
      x = longint'(cur_x);
      y = longint'(cur_y);
      ps.x_right = OUT_W'(ox + x);
      ps.x_left = OUT_W'(ox - x);
      ps.y_below = OUT_W'(oy + y);
      ps.y_above = OUT_W'(oy - y);
      ps.point_valid = 1'b1;
      ps.done_res = (y <= 0);
      if (y <= 0) tracing = 1'b0;
   endtask

   // offer one transaction and log its expected point set once it is taken
   task automatic send_item(input logic cmd, input logic [COORD_BITS-1:0] cx,
                            input logic [COORD_BITS-1:0] cy,
                            input logic [RADIUS_BITS-1:0] rx,
                            input logic [RADIUS_BITS-1:0] ry,
                            input logic known, input point_set_type want);
      point_set_type ps;
      while (!calm && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_centre_x <= cx;
      req_centre_y <= cy;
      req_radius_horiz <= rx;
      req_radius_vert <= ry;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_point_set(cmd, cx, cy, rx, ry, ps);
      point_sets_due.push_back(known ? want : ps);
      items_sent++;
      calm <= (items_sent >= 150 && items_sent < 250);
   endtask

   task automatic send_step();
      send_item(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                RADIUS_BITS'($urandom), RADIUS_BITS'($urandom), 1'b0, NO_SET);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      err_count++;
   endtask

   task automatic check_point_set();
      point_set_type want;
      if (point_sets_due.size() == 0) begin
         report_mismatch("point set with none pending", 0, 0);
      end else begin
         want = point_sets_due.pop_front();
         if (rsp_x_right !== want.x_right)
            report_mismatch("x_right", longint'(rsp_x_right), longint'(want.x_right));
         if (rsp_x_left !== want.x_left)
            report_mismatch("x_left", longint'(rsp_x_left), longint'(want.x_left));
         if (rsp_y_below !== want.y_below)
            report_mismatch("y_below", longint'(rsp_y_below), longint'(want.y_below));
         if (rsp_y_above !== want.y_above)
            report_mismatch("y_above", longint'(rsp_y_above), longint'(want.y_above));
         if (rsp_point_valid !== want.point_valid)
            report_mismatch("point_valid", longint'(rsp_point_valid),
                            longint'(want.point_valid));
         if (rsp_done_res !== want.done_res)
            report_mismatch("done_res", longint'(rsp_done_res), longint'(want.done_res));
      end
   endtask

   // receiver: random back-pressure plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_point_set();
            got_count++;
         end
         if (got_count == HOLD_AT && !held_off) begin
            held_off = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 28);
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int pick, size_pick, cut, steps, extra;
      logic [RADIUS_BITS-1:0] rx, ry;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_N; i++) begin
         send_item(dir_rows[i].cmd, dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].rx,
                   dir_rows[i].ry, dir_rows[i].known, dir_rows[i].want);
      end

      while (items_sent < DIR_N + RAND_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            // noise: any command with any payload
            send_item(1'($urandom_range(1)), COORD_BITS'($urandom), COORD_BITS'($urandom),
                      RADIUS_BITS'($urandom), RADIUS_BITS'($urandom), 1'b0, NO_SET);
         end else begin
            size_pick = $urandom_range(99);
            cut = 100000;
            if (size_pick < 80) begin
               rx = RADIUS_BITS'($urandom_range(12));
               ry = RADIUS_BITS'($urandom_range(12));
            end else if (size_pick < 92) begin
               rx = RADIUS_BITS'($urandom_range(40));
               ry = RADIUS_BITS'($urandom_range(40));
            end else begin
               // large ellipse: trace a few points and abandon it
               rx = RADIUS_BITS'($urandom);
               ry = RADIUS_BITS'($urandom);
               cut = $urandom_range(1, 20);
            end
            if ($urandom_range(99) < 15) cut = $urandom_range(0, 6);
            send_item(CMD_START, COORD_BITS'($urandom), COORD_BITS'($urandom), rx, ry,
                      1'b0, NO_SET);
            steps = 0;
            while (tracing && steps < cut) begin
               send_step();
               steps++;
            end
            extra = $urandom_range(2);
            repeat (extra) send_step();
         end
      end

      req_valid <= 1'b0;
      while (point_sets_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (err_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
